/* design/mmcs_pkg.sv */
// mmcs_pkg: shared types and constants for the manifest marker capture scanner
// holds marker byte tables, buffer sizing and the beat payload structs
// no dependencies
package mmcs_pkg;

    // capture buffer size in bytes, begin marker included; at most BUFFER_BYTES - 1 are kept
    localparam int BUFFER_BYTES = 512;
    localparam int LEN_W        = $clog2(BUFFER_BYTES);
    localparam int IDX_W        = 9;

    localparam int BEGIN_LEN  = 25;
    localparam int END_LEN    = 23;
    localparam int WIN_LEN    = END_LEN - 1;
    localparam int PROG_W     = 5;

    localparam logic ACTION_FEED  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    // begin marker bytes, first character at index 0
    localparam logic [7:0] BEGIN_MARK [BEGIN_LEN] = '{
        8'h49, 8'h4E, 8'h41, 8'h53, 8'h5F, 8'h46, 8'h57, 8'h5F,
        8'h4D, 8'h41, 8'h4E, 8'h49, 8'h46, 8'h45, 8'h53, 8'h54,
        8'h5F, 8'h56, 8'h31, 8'h5F, 8'h42, 8'h45, 8'h47, 8'h49,
        8'h4E
    };

    // end marker bytes, first character at index 0
    localparam logic [7:0] END_MARK [END_LEN] = '{
        8'h49, 8'h4E, 8'h41, 8'h53, 8'h5F, 8'h46, 8'h57, 8'h5F,
        8'h4D, 8'h41, 8'h4E, 8'h49, 8'h46, 8'h45, 8'h53, 8'h54,
        8'h5F, 8'h56, 8'h31, 8'h5F, 8'h45, 8'h4E, 8'h44
    };

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } in_beat_t;

    typedef struct packed {
        logic             stored;
        logic [IDX_W-1:0] stored_index;
        logic             capturing;
        logic             complete;
        logic             overflowed;
    } out_beat_t;

endpackage

/* design/mmcs_in_if.sv */
// mmcs_in_if: valid/ready channel carrying scanner input beats
// depends on mmcs_pkg for the payload struct
interface mmcs_in_if;
    import mmcs_pkg::*;

    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/mmcs_out_if.sv */
// mmcs_out_if: valid/ready channel carrying scanner result beats
// depends on mmcs_pkg for the payload struct
interface mmcs_out_if;
    import mmcs_pkg::*;

    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/manifest_marker_capture_scanner.sv */
// manifest_marker_capture_scanner: begin/end marker scanner with capture tracking
// depends on mmcs_pkg, mmcs_in_if and mmcs_out_if

// The scanner takes one input beat per clock and returns exactly one result
// beat per input beat, in the cycle after acceptance. The whole update (begin
// marker progress, a 23-byte parallel compare against the end marker and the
// position counter) settles between the input handshake and the result
// register, so a new beat is taken every cycle as long as the result register
// is empty or being drained in the same cycle. A clear beat returns all state
// to reset and produces an all-zero result. Captured bytes themselves are not
// kept beyond the 22-byte tail window needed for the end marker compare.
module manifest_marker_capture_scanner (
    input  logic        clk,
    input  logic        rst_n,
    mmcs_in_if.sink     in_ch,
    mmcs_out_if.source  out_ch
);
    import mmcs_pkg::*;

    logic [PROG_W-1:0] progress_reg, progress_next;
    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [7:0]        window_reg [WIN_LEN];
    logic [7:0]        window_next [WIN_LEN];
    logic              out_valid_reg;
    out_beat_t         out_data_reg, out_data_next;
    logic              accept;
    logic              end_match;
    logic [7:0]        b;

    // result register drains or is empty: take a new beat
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data.byte_value;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // end marker compare over the tail window plus the incoming byte
    always_comb
    begin
        end_match = (b == END_MARK[END_LEN-1]);
        for (int i = 0; i < WIN_LEN; i++)
        begin
            if (window_reg[i] != END_MARK[i])
                end_match = 1'b0;
        end
    end

    // next state and result for the beat on the input
    always_comb
    begin
        progress_next = progress_reg;
        active_next   = active_reg;
        done_next     = done_reg;
        ovf_next      = ovf_reg;
        length_next   = length_reg;
        window_next   = window_reg;
        out_data_next = '0;

        if (in_ch.data.action == ACTION_CLEAR)
        begin
            progress_next = '0;
            active_next   = 1'b0;
            done_next     = 1'b0;
            ovf_next      = 1'b0;
            length_next   = '0;
        end
        else if (!done_reg && !ovf_reg)
        begin
            if (!active_reg)
            begin
                // naive begin marker match
                if (b == BEGIN_MARK[progress_reg])
                begin
                    if (progress_reg == PROG_W'(BEGIN_LEN - 1))
                    begin
                        progress_next = PROG_W'(BEGIN_LEN);
                        active_next   = 1'b1;
                        length_next   = LEN_W'(BEGIN_LEN);
                        for (int i = 0; i < WIN_LEN; i++)
                            window_next[i] = BEGIN_MARK[BEGIN_LEN - WIN_LEN + i];
                    end
                    else
                    begin
                        progress_next = progress_reg + PROG_W'(1);
                    end
                end
                else if (b == BEGIN_MARK[0])
                begin
                    progress_next = PROG_W'(1);
                end
                else
                begin
                    progress_next = '0;
                end
            end
            else if (length_reg >= LEN_W'(BUFFER_BYTES - 1))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                // append the byte and shift the tail window
                out_data_next.stored       = 1'b1;
                out_data_next.stored_index = IDX_W'(length_reg);
                length_next                = length_reg + LEN_W'(1);
                for (int i = 0; i < WIN_LEN - 1; i++)
                    window_next[i] = window_reg[i+1];
                window_next[WIN_LEN-1] = b;
                if (end_match)
                    done_next = 1'b1;
            end
        end

        out_data_next.capturing  = active_next;
        out_data_next.complete   = done_next;
        out_data_next.overflowed = ovf_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg  <= '0;
            active_reg    <= 1'b0;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                progress_reg <= progress_next;
                active_reg   <= active_next;
                done_reg     <= done_next;
                ovf_reg      <= ovf_next;
                length_reg   <= length_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg   <= window_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule
